@@ sv/averaged_integral_brightness_loop_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the averaged integral brightness loop.
// Each macro expects clk and rst in scope and stays quiet while rst is high.
// ----------------------------------------------------------------------------
`ifndef AVERAGED_INTEGRAL_BRIGHTNESS_LOOP_ASSERT_SVH
`define AVERAGED_INTEGRAL_BRIGHTNESS_LOOP_ASSERT_SVH

// Check a condition at every clock edge out of reset.
`define AIBL_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check a consequence in the cycle after an antecedent.
`define AIBL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/aibl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aibl_pkg
// Shared types and constants of the averaged integral brightness loop.
// ----------------------------------------------------------------------------
package aibl_pkg;

  localparam int Q16_W          = 16;
  localparam int CORR_W         = 17;
  localparam int WINDOW_DEFAULT = 5;

  typedef logic [Q16_W-1:0]         q16_t;
  typedef logic signed [CORR_W-1:0] corr_t;

  localparam q16_t GAIN_RESET = 16'd655;
  localparam q16_t DUTY_RESET = 16'd32768;
  localparam q16_t DUTY_MAX   = 16'hFFFF;

  // One window entry: both samples share a slot.
  typedef struct packed {
    q16_t setpoint;
    q16_t light;
  } sample_pair_t;

  // Window store control from the pipeline.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } win_ctrl_t;

endpackage

@@ sv/aibl_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aibl_if
// Valid/ready channels for sample requests and loop results.
// ----------------------------------------------------------------------------
interface aibl_sample_if;
  logic             valid;
  logic             ready;
  aibl_pkg::q16_t   setpoint_sample;
  aibl_pkg::q16_t   light_sample;

  modport source (output valid, output setpoint_sample, output light_sample, input ready);
  modport sink   (input valid, input setpoint_sample, input light_sample, output ready);
endinterface

interface aibl_result_if;
  logic             valid;
  logic             ready;
  aibl_pkg::q16_t   duty;
  aibl_pkg::q16_t   setpoint_mean;
  aibl_pkg::q16_t   light_mean;
  aibl_pkg::corr_t  correction;

  modport source (output valid, output duty, output setpoint_mean, output light_mean,
                  output correction, input ready);
  modport sink   (input valid, input duty, input setpoint_mean, input light_mean,
                  input correction, output ready);
endinterface

@@ sv/aibl_window_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aibl_window_store
// Sample window memory with registered read, per-entry valid bits and
// write-to-read forwarding.
// ----------------------------------------------------------------------------
module aibl_window_store #(
  parameter int WINDOW = aibl_pkg::WINDOW_DEFAULT,
  parameter int SLOT_W = 3
) (
  input  logic                 clk,
  input  logic                 rst,
  input  aibl_pkg::win_ctrl_t  ctrl,
  input  logic [SLOT_W-1:0]    rd_slot,
  input  logic [SLOT_W-1:0]    wr_slot,
  input  aibl_pkg::sample_pair_t wr_data,
  output aibl_pkg::sample_pair_t rd_data
);
  import aibl_pkg::*;

  sample_pair_t      mem [WINDOW];
  sample_pair_t      mem_q;
  sample_pair_t      fwd_data;
  logic              fwd;
  logic              live;
  logic [WINDOW-1:0] entry_valid;

  // Memory array: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[wr_slot] <= wr_data;
    end
    if (ctrl.rd_en) begin
      mem_q    <= mem[rd_slot];
      fwd_data <= wr_data;
    end
  end

  // Entries never written read as zero; a same-slot write wins over the array.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      fwd         <= 1'b0;
      live        <= 1'b0;
    end else begin
      if (ctrl.wr_en) begin
        entry_valid[wr_slot] <= 1'b1;
      end
      if (ctrl.rd_en) begin
        fwd  <= ctrl.wr_en && (wr_slot == rd_slot);
        live <= entry_valid[rd_slot];
      end
    end
  end

  assign rd_data = fwd ? fwd_data : (live ? mem_q : '0);

endmodule

@@ sv/averaged_integral_brightness_loop.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// averaged_integral_brightness_loop
// Integral brightness controller over moving averages of setpoint and light.
// ----------------------------------------------------------------------------
// Each request carries a setpoint and a light sample (unsigned Q0.16). Both
// go into WINDOW-deep sliding windows held in one synchronous memory; the
// running sums are divided by WINDOW (truncated), the mean error times the
// Q0.16 gain, floored by 2^16, is the correction, and the duty (reset 0.5)
// takes the correction with saturation to 0..65535. The block takes one
// request per cycle while results are taken, through the five-stage pipe:
// window read, running-sum update, reciprocal divide, gain multiply, duty
// accumulate. The window memory is read at the accepting edge; its data is
// used, and the entry written, as the request leaves the first stage; a
// read of the slot being written in the same cycle is forwarded. The gain
// register takes gain_wdata at any edge with gain_we high and should be
// written only while no request is in flight.
// ----------------------------------------------------------------------------
`include "averaged_integral_brightness_loop_assert.svh"

module averaged_integral_brightness_loop #(
  parameter int WINDOW = aibl_pkg::WINDOW_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            gain_we,
  input  aibl_pkg::q16_t  gain_wdata,
  aibl_sample_if.sink     sample,
  aibl_result_if.source   result
);
  import aibl_pkg::*;

  localparam int LOGW   = $clog2(WINDOW);
  localparam int SLOT_W = (WINDOW > 1) ? LOGW : 1;
  localparam int SUMW   = Q16_W + LOGW;
  localparam int SHIFT  = SUMW + LOGW;
  localparam int MPROD_W = 2 * SUMW + 1;
  localparam int PROD_W = 2 * Q16_W + 1;
  // Reciprocal of WINDOW, rounded up: exact truncating divide for any sum.
  localparam longint unsigned RECIP_L = ((64'd1 << SHIFT) + WINDOW - 1) / WINDOW;
  localparam logic [SUMW:0]   RECIP   = RECIP_L[SUMW:0];
  localparam logic [SUMW-1:0] SUM_MAX = SUMW'(WINDOW * 65535);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);

  // Configuration and loop state.
  q16_t              gain;
  q16_t              duty_level;
  logic [SLOT_W-1:0] slot;
  logic [SUMW-1:0]   sp_sum;
  logic [SUMW-1:0]   li_sum;

  // Pipe stage valids and handshake.
  logic v1, v2, v3, v4, out_valid;
  logic rdy1, rdy2, rdy3, rdy4, rdy_out;
  logic accept;
  logic duty_load;

  // Stage payloads.
  sample_pair_t      s1_new;
  logic [SLOT_W-1:0] s1_slot;
  sample_pair_t      old;
  logic [SUMW-1:0]   sp_sum_next, li_sum_next;
  logic [SUMW-1:0]   s2_sp_sum, s2_li_sum;
  logic [MPROD_W-1:0] sp_mprod, li_mprod;
  q16_t              s3_sp_mean, s3_li_mean;
  logic signed [Q16_W:0]   err;
  logic signed [PROD_W-1:0] prod_full;
  logic signed [PROD_W-1:0] s4_prod;
  q16_t              s4_sp_mean, s4_li_mean;
  corr_t             corr;
  logic              corr_neg;
  logic signed [Q16_W+1:0] duty_sum;
  q16_t              duty_next;
  q16_t              out_sp_mean, out_li_mean;
  corr_t             out_corr;

  win_ctrl_t         win_ctrl;

  // Ready ripples back from the output register; a bubble anywhere lets the
  // input side keep moving.
  assign rdy_out = !out_valid || result.ready;
  assign rdy4    = !v4 || rdy_out;
  assign rdy3    = !v3 || rdy4;
  assign rdy2    = !v2 || rdy3;
  assign rdy1    = !v1 || rdy2;
  assign accept  = sample.valid && rdy1;
  assign sample.ready = rdy1;

  // Load the duty and the result register as a request leaves stage 4.
  assign duty_load = rdy_out && v4;

  // Read the slot on acceptance; write it back as the request leaves stage 1.
  assign win_ctrl.rd_en = accept;
  assign win_ctrl.wr_en = v1 && rdy2;

  aibl_window_store #(
    .WINDOW (WINDOW),
    .SLOT_W (SLOT_W)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (win_ctrl),
    .rd_slot (slot),
    .wr_slot (s1_slot),
    .wr_data (s1_new),
    .rd_data (old)
  );

  // Running sums: drop the oldest entry, add the new one.
  assign sp_sum_next = sp_sum - SUMW'(old.setpoint) + SUMW'(s1_new.setpoint);
  assign li_sum_next = li_sum - SUMW'(old.light) + SUMW'(s1_new.light);

  // Divide by WINDOW through the reciprocal.
  assign sp_mprod = MPROD_W'(s2_sp_sum) * MPROD_W'(RECIP);
  assign li_mprod = MPROD_W'(s2_li_sum) * MPROD_W'(RECIP);

  // Error times gain; the product fits 33 bits.
  assign err       = $signed({1'b0, s3_sp_mean}) - $signed({1'b0, s3_li_mean});
  assign prod_full = err * $signed({1'b0, gain});

  // Floor shift by 16 is the top bits of the product; then saturate the duty.
  assign corr     = s4_prod[PROD_W-1:Q16_W];
  assign corr_neg = corr[CORR_W-1];
  assign duty_sum = $signed({2'b00, duty_level}) + (Q16_W+2)'(corr);

  always_comb begin
    if (duty_sum < 0) begin
      duty_next = '0;
    end else if (duty_sum > $signed({2'b00, DUTY_MAX})) begin
      duty_next = DUTY_MAX;
    end else begin
      duty_next = duty_sum[Q16_W-1:0];
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      gain       <= GAIN_RESET;
      duty_level <= DUTY_RESET;
      slot       <= '0;
      sp_sum     <= '0;
      li_sum     <= '0;
      v1         <= 1'b0;
      v2         <= 1'b0;
      v3         <= 1'b0;
      v4         <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (gain_we) begin
        gain <= gain_wdata;
      end
      if (accept) begin
        slot <= (slot == SLOT_LAST) ? '0 : slot + 1'b1;
      end
      if (win_ctrl.wr_en) begin
        sp_sum <= sp_sum_next;
        li_sum <= li_sum_next;
      end
      if (duty_load) begin
        duty_level <= duty_next;
      end
      if (rdy1) begin
        v1 <= sample.valid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
      if (rdy4) begin
        v4 <= v3;
      end
      if (rdy_out) begin
        out_valid <= v4;
      end
    end
  end

  // Payload registers: advance only when the stage ahead takes them.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_new.setpoint <= sample.setpoint_sample;
      s1_new.light    <= sample.light_sample;
      s1_slot         <= slot;
    end
    if (rdy2 && v1) begin
      s2_sp_sum <= sp_sum_next;
      s2_li_sum <= li_sum_next;
    end
    if (rdy3 && v2) begin
      s3_sp_mean <= sp_mprod[SHIFT +: Q16_W];
      s3_li_mean <= li_mprod[SHIFT +: Q16_W];
    end
    if (rdy4 && v3) begin
      s4_prod    <= prod_full;
      s4_sp_mean <= s3_sp_mean;
      s4_li_mean <= s3_li_mean;
    end
    if (duty_load) begin
      out_sp_mean <= s4_sp_mean;
      out_li_mean <= s4_li_mean;
      out_corr    <= corr;
    end
  end

  // Duty state doubles as the result's duty; it only changes on a load.
  assign result.valid         = out_valid;
  assign result.duty          = duty_level;
  assign result.setpoint_mean = out_sp_mean;
  assign result.light_mean    = out_li_mean;
  assign result.correction    = out_corr;

  `AIBL_ASSERT_ALWAYS(a_slot_range, slot <= SLOT_LAST, "write slot beyond window")
  `AIBL_ASSERT_ALWAYS(a_sp_sum_bound, sp_sum <= SUM_MAX, "setpoint sum overflow")
  `AIBL_ASSERT_ALWAYS(a_li_sum_bound, li_sum <= SUM_MAX, "light sum overflow")
  `AIBL_ASSERT_NEXT(a_duty_up, duty_load && !corr_neg, duty_level >= $past(duty_level), "duty fell")
  `AIBL_ASSERT_NEXT(a_duty_dn, duty_load && corr_neg, duty_level <= $past(duty_level), "duty rose")

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the averaged integral brightness loop.
// ----------------------------------------------------------------------------
// Requests of setpoint and light samples go in through the sample channel.
// Results come back on the result channel. A scoreboard class tracks its own
// copy of the windows, running sums, duty and gain. For every accepted request
// it predicts the duty, both means and the correction, and it checks each
// result against the oldest prediction. The run has a short directed part,
// then random phases under several gain settings. Both channels stall at
// random, and in some phases one side runs with no stalls at all.
// ----------------------------------------------------------------------------
module tb_top;
  import aibl_pkg::*;

  localparam int WIN       = WINDOW_DEFAULT;
  localparam int DRAIN_CYC = 8;     // settling slack after the last result
  localparam int PHASE_LEN = 230;   // random requests per phase

  // One predicted result, in the widths of the result channel.
  typedef struct packed {
    q16_t  duty;
    q16_t  sp_avg;
    q16_t  li_avg;
    corr_t corr;
  } loop_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: mirror of the loop state plus a queue of predicted results.
  // --------------------------------------------------------------------------
  class loop_scoreboard;
    q16_t           sp_hist [WIN];
    q16_t           li_hist [WIN];
    int             hist_slot;
    logic [18:0]    sp_total;
    logic [18:0]    li_total;
    q16_t           duty_now;
    q16_t           loop_gain;
    loop_result_t   expected_results[$];
    int             errors;

    function new();
      foreach (sp_hist[i]) begin
        sp_hist[i] = '0;
        li_hist[i] = '0;
      end
      hist_slot = 0;
      sp_total  = '0;
      li_total  = '0;
      duty_now  = DUTY_RESET;
      loop_gain = GAIN_RESET;
      errors    = 0;
    endfunction

    function void set_gain(q16_t g);
      loop_gain = g;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // Advance the mirrored state by one accepted request and queue its result.
    function void note_request(q16_t sp, q16_t li);
      loop_result_t r;
      longint       err;
      longint       fix;
      longint       next_duty;

      sp_total = sp_total - sp_hist[hist_slot] + sp;
      li_total = li_total - li_hist[hist_slot] + li;
      sp_hist[hist_slot] = sp;
      li_hist[hist_slot] = li;
      hist_slot = (hist_slot == WIN - 1) ? 0 : hist_slot + 1;

      r.sp_avg = q16_t'(sp_total / WIN);
      r.li_avg = q16_t'(li_total / WIN);

      // Arithmetic shift of a signed product floors toward minus infinity.
      err = longint'(r.sp_avg) - longint'(r.li_avg);
      fix = (err * longint'(loop_gain)) >>> 16;

      next_duty = longint'(duty_now) + fix;
      if (next_duty < 0) next_duty = 0;
      if (next_duty > longint'(DUTY_MAX)) next_duty = longint'(DUTY_MAX);
      duty_now = q16_t'(next_duty);

      r.duty = duty_now;
      r.corr = corr_t'(fix);
      expected_results.push_back(r);
    endfunction

    function void compare_field(string name, logic signed [31:0] exp_v,
                                logic signed [31:0] act_v);
      if (act_v !== exp_v) begin
        $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(q16_t duty, q16_t sp_avg, q16_t li_avg, corr_t corr);
      loop_result_t e;
      if (expected_results.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
        return;
      end
      e = expected_results.pop_front();
      compare_field("duty", e.duty, duty);
      compare_field("setpoint_mean", e.sp_avg, sp_avg);
      compare_field("light_mean", e.li_avg, li_avg);
      compare_field("correction", e.corr, corr);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block itself.
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic gain_we = 1'b0;
  q16_t gain_wdata = '0;

  aibl_sample_if sample_ch ();
  aibl_result_if result_ch ();

  loop_scoreboard sb = new();

  // Stall control: the main sequence switches the stalls off for some phases.
  bit   src_calm  = 1'b0;
  bit   sink_calm = 1'b0;
  int   sink_hold = 0;

  // Previous pair, so random content can repeat a level for a while.
  q16_t last_sp = '0;
  q16_t last_li = '0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  averaged_integral_brightness_loop DUT (
    .clk        (clk),
    .rst        (rst),
    .gain_we    (gain_we),
    .gain_wdata (gain_wdata),
    .sample     (sample_ch),
    .result     (result_ch)
  );

  // Gap length: mostly none or short, now and then a long one.
  function int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(10, 40);
  endfunction

  // --------------------------------------------------------------------------
  // Monitors: note accepted requests, check accepted results. Both sample at
  // the rising edge, where the block's outputs still hold pre-edge values.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && sample_ch.valid && sample_ch.ready)
      sb.note_request(sample_ch.setpoint_sample, sample_ch.light_sample);
    if (!rst && result_ch.valid && result_ch.ready)
      sb.check_result(result_ch.duty, result_ch.setpoint_mean,
                      result_ch.light_mean, result_ch.correction);
  end

  // Result side: hold ready low for a random stretch, then release it.
  always @(negedge clk) begin
    if (sink_hold > 0) begin
      result_ch.ready <= 1'b0;
      sink_hold <= sink_hold - 1;
    end else begin
      result_ch.ready <= 1'b1;
      sink_hold <= pick_gap(sink_calm);
    end
  end

  // --------------------------------------------------------------------------
  // Driver tasks. All of them start and end at a falling edge.
  // --------------------------------------------------------------------------

  // Present one request, hold it until accepted, then idle for a random gap.
  // Valid stays high across back-to-back requests.
  task automatic send_request(q16_t sp, q16_t li);
    int gap;
    sample_ch.valid           <= 1'b1;
    sample_ch.setpoint_sample <= sp;
    sample_ch.light_sample    <= li;
    do @(posedge clk); while (!sample_ch.ready);
    @(negedge clk);
    gap = pick_gap(src_calm);
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Drop valid and wait until every predicted result has come back, then let
  // the pipe settle before anything touches the gain.
  task automatic drain();
    sample_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);
  endtask

  // Write the gain register for one cycle; only called with the loop idle.
  task automatic write_gain(q16_t g);
    gain_we    <= 1'b1;
    gain_wdata <= g;
    @(negedge clk);
    gain_we    <= 1'b0;
    sb.set_gain(g);
  endtask

  // Random request content: mostly uniform, plus extremes, near-equal pairs
  // (small errors of either sign), held levels and tiny values.
  task automatic next_pair(output q16_t sp, output q16_t li);
    int mode;
    mode = $urandom_range(0, 9);
    case (mode)
      4: begin
        sp = $urandom_range(0, 1) ? DUTY_MAX : '0;
        li = $urandom_range(0, 1) ? DUTY_MAX : '0;
      end
      5: begin
        sp = q16_t'($urandom_range(0, 65535));
        li = sp + q16_t'($urandom_range(0, 8)) - q16_t'(4);
      end
      6: begin
        sp = last_sp;
        li = last_li;
      end
      7: begin
        sp = q16_t'($urandom_range(0, 15));
        li = q16_t'($urandom_range(0, 15));
      end
      default: begin
        sp = q16_t'($urandom_range(0, 65535));
        li = q16_t'($urandom_range(0, 65535));
      end
    endcase
    last_sp = sp;
    last_li = li;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    q16_t phase_gain [8];
    q16_t sp;
    q16_t li;

    sample_ch.valid           = 1'b0;
    sample_ch.setpoint_sample = '0;
    sample_ch.light_sample    = '0;

    phase_gain[0] = DUTY_MAX;
    phase_gain[1] = '0;
    phase_gain[2] = 16'd1;
    phase_gain[3] = 16'h8000;
    phase_gain[4] = q16_t'($urandom_range(0, 65535));
    phase_gain[5] = GAIN_RESET;
    phase_gain[6] = q16_t'($urandom_range(0, 65535));
    phase_gain[7] = DUTY_MAX;

    // Hold reset, then release it at a falling edge.
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed, default gain: the means climb from the zeroed windows over
    // the first five requests, the write slot wraps, then the error flips.
    write_gain(GAIN_RESET);
    repeat (6) send_request(DUTY_MAX, '0);
    repeat (6) send_request('0, DUTY_MAX);
    drain();

    // Directed, full gain: push the duty into both rails, and take negative
    // errors where floor and truncation differ.
    write_gain(DUTY_MAX);
    repeat (5) send_request(DUTY_MAX, '0);
    repeat (5) send_request('0, DUTY_MAX);
    send_request(16'h5555, 16'hAAAA);
    send_request(16'hAAAA, 16'h5555);
    send_request(DUTY_MAX, DUTY_MAX);
    drain();

    // Random phases, one gain each. Rotate which side runs without stalls.
    for (int p = 0; p < 8; p++) begin
      write_gain(phase_gain[p]);
      src_calm  = (p % 3 == 1);
      sink_calm = (p % 3 == 2);
      for (int n = 0; n < PHASE_LEN; n++) begin
        next_pair(sp, li);
        send_request(sp, li);
      end
      drain();
    end

    if (sb.errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule
